>>> src/rdwr_pkg.sv
`timescale 1ns / 1ps

package rdwr_pkg;

  // identifier pool geometry
  localparam int NumIds   = 96;
  localparam int MapWords = (NumIds + 31) / 32;
  localparam int TailBits = NumIds % 32;
  localparam int CntW     = $clog2(NumIds + 1);
  localparam int IdW      = 7;
  localparam int LeftW    = 7;
  localparam int WordW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int LogW     = $clog2(CntW + 1);

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RETRY    = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_REFILLED = 2'd3;

  // input command codes
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_REFILL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_BYTE,
    S_BIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic walk;
    logic sel_byte;
    logic sel_bit;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic go_walk;
    logic hit;
    logic last_word;
  } dp_stat_t;

endpackage

>>> src/random_draw_without_replacement_unit.sv
`timescale 1ns / 1ps

// channel  signals                     payload
// in       in_valid_i / in_ready_o     cmd_i, random_word_i
// out      out_valid_o / out_ready_i   picked_id_o, status_o, left_count_o
//
// a draw runs from accept through the range check, a walk over the bitmap words
// by the popcount unit, byte select, bit select and the hand-off into the output
// register; refill, empty and retry go from the range check to the hand-off
// one item is in flight at a time; the next beat is taken while a result waits
// reset restores the full identifier set at once, no clearing pass
// a stalled output holds the result and the finished item waits in the last step

module random_draw_without_replacement_unit import rdwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  picked_id_o,
  output logic [1:0]  status_o,
  output logic [6:0]  left_count_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rdwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  rdwr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .cmd_in_i      (cmd_i),
    .random_word_i (random_word_i),
    .stat_o        (dp_stat),
    .picked_id_o   (picked_id_o),
    .status_o      (status_o),
    .left_count_o  (left_count_o)
  );

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat accepted while an item is in flight");

  a_id_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && picked_id_o != '0 |-> status_o == STAT_OK)
    else $error("nonzero id without ok status");

  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK |-> left_count_o < 7'(NumIds))
    else $error("ok draw left a full set");

  a_refill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_REFILLED |-> left_count_o == 7'(NumIds))
    else $error("refill did not restore the full count");

endmodule

>>> src/rdwr_ctrl.sv
`timescale 1ns / 1ps

module rdwr_ctrl import rdwr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.go_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.hit) begin
          state_d = S_BYTE;
        end else if (stat_i.last_word) begin
          state_d = S_DONE;
        end
      end
      S_BYTE: begin
        cmd_o.sel_byte = 1'b1;
        state_d        = S_BIT;
      end
      S_BIT: begin
        cmd_o.sel_bit = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // wait for the output slot to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/rdwr_dp.sv
`timescale 1ns / 1ps

module rdwr_dp import rdwr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic             cmd_in_i,
  input  logic [31:0]      random_word_i,
  output dp_stat_t         stat_o,
  output logic [IdW-1:0]   picked_id_o,
  output logic [1:0]       status_o,
  output logic [LeftW-1:0] left_count_o
);

  function automatic logic [31:0] fill_word(input int w);
    logic [31:0] v;
    v = 32'hffffffff;
    if (TailBits != 0 && w == MapWords - 1) begin
      v = (32'd1 << TailBits) - 32'd1;
    end
    return v;
  endfunction

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [31:0] c;
    c = (v & 32'h55555555) + ((v >> 1) & 32'h55555555);
    c = (c & 32'h33333333) + ((c >> 2) & 32'h33333333);
    c = (c & 32'h0f0f0f0f) + ((c >> 4) & 32'h0f0f0f0f);
    c = (c & 32'h00ff00ff) + ((c >> 8) & 32'h00ff00ff);
    c = (c & 32'h0000ffff) + (c >> 16);
    return c[5:0];
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

  // smallest k with 2^k >= x
  function automatic logic [LogW-1:0] ceil_log2(input logic [CntW-1:0] x);
    logic [LogW-1:0] k;
    k = LogW'(CntW);
    for (int i = CntW; i >= 0; i--) begin
      if (((CntW + 1)'(1) << i) >= {1'b0, x}) begin
        k = LogW'(i);
      end
    end
    return k;
  endfunction

  logic [31:0]      map_q [MapWords];
  logic [CntW-1:0]  remaining_q;
  logic             cmd_q;
  logic [CntW-1:0]  rnd_q;
  logic [CntW-1:0]  rank_q;
  logic [CntW-1:0]  seen_q;
  logic [WordW-1:0] word_q;
  logic [1:0]       byte_q;
  logic [IdW-1:0]   res_id_q;
  logic [1:0]       res_st_q;
  logic [LeftW-1:0] res_left_q;
  logic [IdW-1:0]   out_id_q;
  logic [1:0]       out_st_q;
  logic [LeftW-1:0] out_left_q;

  logic [LogW-1:0]  k;
  logic [CntW:0]    mask_wide;
  logic [CntW-1:0]  cand;
  logic             in_range;
  logic [31:0]      cur_word;
  logic [5:0]       pc;
  logic [CntW:0]    seen_sum;
  logic             hit;
  logic [1:0]       byte_sel;
  logic [5:0]       byte_base;
  logic [5:0]       prefix;
  logic [7:0]       byte_bits;
  logic [2:0]       bit_sel;
  logic [2:0]       bit_rank;
  logic [3:0]       cnt_bits;
  logic [4:0]       bit_pos;

  assign k         = ceil_log2(remaining_q);
  assign mask_wide = ((CntW + 1)'(1) << k) - (CntW + 1)'(1);
  assign cand      = rnd_q & mask_wide[CntW-1:0];
  assign in_range  = cand < remaining_q;

  assign cur_word = map_q[word_q];
  assign pc       = pop32(cur_word);
  assign seen_sum = {1'b0, seen_q} + (CntW + 1)'(pc);
  assign hit      = seen_sum > {1'b0, rank_q};

  assign stat_o.go_walk   = (cmd_q == CMD_DRAW) && (remaining_q != '0) && in_range;
  assign stat_o.hit       = hit;
  assign stat_o.last_word = (int'(word_q) == MapWords - 1);

  // pick the byte that holds the local rank
  always_comb begin
    byte_sel  = 2'd3;
    byte_base = '0;
    prefix    = '0;
    for (int b = 3; b >= 0; b--) begin
      prefix = '0;
      for (int j = 0; j < b; j++) begin
        prefix = prefix + 6'(pop8(cur_word[j*8 +: 8]));
      end
      if ((prefix + 6'(pop8(cur_word[b*8 +: 8]))) > 6'(rank_q)) begin
        byte_sel  = 2'(b);
        byte_base = prefix;
      end
    end
  end

  // pick the bit inside the chosen byte
  always_comb begin
    byte_bits = cur_word[byte_q*8 +: 8];
    bit_rank  = rank_q[2:0];
    bit_sel   = '0;
    cnt_bits  = '0;
    for (int i = 7; i >= 0; i--) begin
      cnt_bits = '0;
      for (int j = 0; j < i; j++) begin
        cnt_bits = cnt_bits + {3'd0, byte_bits[j]};
      end
      if (byte_bits[i] && cnt_bits == {1'b0, bit_rank}) begin
        bit_sel = 3'(i);
      end
    end
  end

  assign bit_pos = {byte_q, bit_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MapWords; w++) begin
        map_q[w] <= fill_word(w);
      end
      remaining_q <= CntW'(NumIds);
    end else begin
      if (cmd_i.check && cmd_q == CMD_REFILL) begin
        for (int w = 0; w < MapWords; w++) begin
          map_q[w] <= fill_word(w);
        end
        remaining_q <= CntW'(NumIds);
      end else if (cmd_i.sel_bit) begin
        map_q[word_q][bit_pos] <= 1'b0;
        remaining_q            <= remaining_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_in_i;
      rnd_q <= random_word_i[CntW-1:0];
    end
    if (cmd_i.check) begin
      rank_q <= cand;
      seen_q <= '0;
      word_q <= '0;
      res_id_q <= '0;
      if (cmd_q == CMD_REFILL) begin
        res_st_q   <= STAT_REFILLED;
        res_left_q <= LeftW'(NumIds);
      end else if (remaining_q == '0) begin
        res_st_q   <= STAT_EMPTY;
        res_left_q <= '0;
      end else begin
        res_st_q   <= STAT_RETRY;
        res_left_q <= LeftW'(remaining_q);
      end
    end
    if (cmd_i.walk) begin
      if (hit) begin
        rank_q <= rank_q - seen_q;
      end else begin
        seen_q <= seen_sum[CntW-1:0];
        word_q <= word_q + WordW'(1);
      end
    end
    if (cmd_i.sel_byte) begin
      byte_q <= byte_sel;
      rank_q <= rank_q - CntW'(byte_base);
    end
    if (cmd_i.sel_bit) begin
      res_id_q   <= IdW'(int'(word_q) * 32 + int'(bit_pos));
      res_st_q   <= STAT_OK;
      res_left_q <= LeftW'(remaining_q - CntW'(1));
    end
    if (cmd_i.push) begin
      out_id_q   <= res_id_q;
      out_st_q   <= res_st_q;
      out_left_q <= res_left_q;
    end
  end

  assign picked_id_o  = out_id_q;
  assign status_o     = out_st_q;
  assign left_count_o = out_left_q;

endmodule

>>> test/tb_random_draw_without_replacement_unit.sv
`timescale 1ns / 1ps

module tb_random_draw_without_replacement_unit;
  import rdwr_pkg::*;

  typedef struct packed {
    logic [IdW-1:0]   picked_id;
    logic [1:0]       status;
    logic [LeftW-1:0] left_count;
  } draw_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        cmd_i         = CMD_DRAW;
  logic [31:0] random_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [6:0]  picked_id_o;
  logic [1:0]  status_o;
  logic [6:0]  left_count_o;

  // shadow of the identifier pool
  logic [NumIds-1:0] pool_free;
  int unsigned       pool_left;

  draw_result_t pending_draws[$];
  bit           calm = 1'b0;
  int unsigned  err_count = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_ok = 0, n_retry = 0, n_empty = 0, n_refill = 0;

  random_draw_without_replacement_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .random_word_i(random_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .picked_id_o  (picked_id_o),
    .status_o     (status_o),
    .left_count_o (left_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** random_draw_without_replacement_unit: FAILED **");
    $finish;
  end

  // update the pool for one accepted beat and queue what the block must return
  task automatic predict_draw(input logic cmd, input logic [31:0] word);
    draw_result_t r;
    int unsigned  width;
    logic [63:0]  mask;
    logic [31:0]  rank;
    int unsigned  seen;
    bit           hit;
    r     = '{picked_id: '0, status: STAT_RETRY, left_count: '0};
    width = 0;
    seen  = 0;
    hit   = 1'b0;
    if (cmd == CMD_REFILL) begin
      pool_free = '1;
      pool_left = NumIds;
      r.status  = STAT_REFILLED;
    end else if (pool_left == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      while ((64'd1 << width) < pool_left) width++;
      mask = (64'd1 << width) - 64'd1;
      rank = word & mask[31:0];
      if (rank < pool_left) begin
        // rank-th free id, lowest index first
        for (int i = 0; i < NumIds; i++) begin
          if (!hit && pool_free[i]) begin
            if (seen == rank) begin
              hit          = 1'b1;
              pool_free[i] = 1'b0;
              pool_left--;
              r.picked_id  = i[IdW-1:0];
              r.status     = STAT_OK;
            end
            seen++;
          end
        end
      end
    end
    r.left_count = pool_left[LeftW-1:0];
    case (r.status)
      STAT_OK:       n_ok++;
      STAT_RETRY:    n_retry++;
      STAT_EMPTY:    n_empty++;
      STAT_REFILLED: n_refill++;
      default: ;
    endcase
    pending_draws.push_back(r);
  endtask

  // returns at the edge where the beat was taken, valid still high
  task automatic send_beat(input logic cmd, input logic [31:0] word);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    random_word_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_draw(cmd, word);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom;
    if (sel < 85) return $urandom_range(0, 127);
    return $urandom | 32'h7f;
  endfunction

  // result side: compare each beat with the oldest prediction, then stall at random
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result: picked_id %0d status %0d left_count %0d",
               picked_id_o, status_o, left_count_o);
        err_count++;
      end else begin
        want = pending_draws.pop_front();
        n_checked++;
        if (picked_id_o !== want.picked_id) begin
          $error("picked_id mismatch: expected %0d, actual %0d", want.picked_id, picked_id_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          err_count++;
        end
        if (left_count_o !== want.left_count) begin
          $error("left_count mismatch: expected %0d, actual %0d",
                 want.left_count, left_count_o);
          err_count++;
        end
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 8);
  end

  task automatic test_edge_words();
    send_beat(CMD_DRAW, 32'h0000_0000);   // lowest id
    send_beat(CMD_DRAW, 32'hffff_ffff);   // rank 127 past the count
    send_beat(CMD_DRAW, 32'd94);          // highest rank still in range
    send_beat(CMD_DRAW, 32'd94);          // rank equal to the count
    send_beat(CMD_DRAW, 32'd93);
    send_beat(CMD_DRAW, 32'd31);
    send_beat(CMD_DRAW, 32'd32);
    send_beat(CMD_DRAW, 32'd63);
    send_beat(CMD_DRAW, 32'd64);
    send_beat(CMD_DRAW, 32'h8000_0040);   // high bits are masked away
    send_beat(CMD_DRAW, 32'h5555_5555);
    send_beat(CMD_DRAW, 32'haaaa_aaaa);
    send_beat(CMD_REFILL, 32'hffff_ffff); // word ignored on refill
    send_beat(CMD_REFILL, 32'h0000_0000);
    send_beat(CMD_DRAW, 32'd95);
    send_beat(CMD_DRAW, 32'd96);
    wait_results();
  endtask

  // drain the pool down through one id left and into the empty state
  task automatic test_exhaust_pool();
    while (pool_left != 0) send_beat(CMD_DRAW, $urandom);
    send_beat(CMD_DRAW, 32'h0000_0000);
    send_beat(CMD_DRAW, 32'hffff_ffff);
    send_beat(CMD_DRAW, $urandom);
    send_beat(CMD_REFILL, $urandom);
    wait_results();
  endtask

  task automatic test_pause_for_results();
    repeat (6) send_beat(CMD_DRAW, pick_word());
    wait_results();
    repeat (6) send_beat(CMD_DRAW, pick_word());
    send_beat(CMD_REFILL, $urandom);
    wait_results();
  endtask

  // runs of draws of random length, each closed by a refill, some refills in between
  task automatic test_random_runs();
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < 1000) begin
      run_len = $urandom_range(8, 170);
      calm    = (sent >= 300 && sent < 500);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(99) < 3) send_beat(CMD_REFILL, $urandom);
        else send_beat(CMD_DRAW, pick_word());
        sent++;
      end
      send_beat(CMD_REFILL, $urandom);
      sent++;
    end
    calm = 1'b0;
    wait_results();
  endtask

  initial begin
    pool_free = '1;
    pool_left = NumIds;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_words();
    test_exhaust_pool();
    test_pause_for_results();
    test_random_runs();

    repeat (20) @(posedge clk_i);
    $display("checked %0d results: %0d draws ok, %0d retries, %0d on an empty set, %0d refills",
             n_checked, n_ok, n_retry, n_empty, n_refill);
    $display("covered mask and bound edges, a fully drained pool and random draw runs");
    if (err_count == 0 && pending_draws.size() == 0) begin
      $display("** random_draw_without_replacement_unit: PASSED **");
    end else begin
      $display("** random_draw_without_replacement_unit: FAILED **");
    end
    $finish;
  end

endmodule
